// ===== src/qvr_pkg.sv =====
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared widths, types and register codes for the quaternion rotation core.
// ----------------------------------------------------------------------------
`default_nettype none

package qvr_pkg;

  localparam int COORD_W    = 32;  // point coordinate width, Q16.16
  localparam int QUAT_W     = 16;  // quaternion component width
  localparam int QUAT_FRAC  = 14;  // quaternion fraction bits, Q1.14

  localparam int PAIR_W     = 2 * QUAT_W;              // q_i * q_j
  localparam int ENTRY_W    = PAIR_W + 1;              // sum of two pair products
  localparam int PROD_W     = COORD_W + ENTRY_W;       // coord * matrix entry
  localparam int DOT_W      = PROD_W + 2;              // sum of three products
  localparam int SHIFT      = 2 * QUAT_FRAC - 1;       // 2F fraction bits, times two
  localparam int CORR_W     = DOT_W - SHIFT;
  localparam int RES_W      = ((CORR_W > COORD_W) ? CORR_W : COORD_W) + 1;

  localparam int CFG_IDX_W  = 2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [QUAT_W-1:0]  quat_t;
  typedef logic signed [PAIR_W-1:0]  pair_t;
  typedef logic signed [ENTRY_W-1:0] entry_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUAT_W = 2'd0,
    REG_QUAT_X = 2'd1,
    REG_QUAT_Y = 2'd2,
    REG_QUAT_Z = 2'd3
  } cfg_reg_t;

  localparam quat_t QUAT_ONE = QUAT_W'(1) << QUAT_FRAC;

endpackage

`default_nettype wire

// ===== src/quaternion_vector_rotation_core.sv =====
// ----------------------------------------------------------------------------
// quaternion_vector_rotation_core
// Rotates a stream of Q16.16 points by a Q1.14 quaternion held in registers.
// ----------------------------------------------------------------------------
// Throughput: one point per cycle; the five stages stall together when the
//   output register is full and not taken.
// Reset (rst, synchronous): clears all valid bits, quaternion to (1, 0, 0, 0).
`default_nettype none

module quaternion_vector_rotation_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [3*qvr_pkg::COORD_W-1:0] s_tdata,  // vec_x, vec_y, vec_z
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic [3*qvr_pkg::COORD_W-1:0]     m_tdata,   // rot_x, rot_y, rot_z
  output logic                              m_tuser,   // overflow
  input  wire logic                         cfg_we,
  input  wire logic [qvr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [qvr_pkg::QUAT_W-1:0]   cfg_data
);
  import qvr_pkg::*;

  quat_t  qw, qx, qy, qz;
  logic   adv;
  logic   v1, v2, v3, v4, v5;

  coord_t px1, py1, pz1, px2, py2, pz2;
  pair_t  xx, xy, xz, xw, yy, yz, yw, zz, zw;
  entry_t e00, e01, e02, e10, e11, e12, e20, e21, e22;

  coord_t rot_x, rot_y, rot_z;
  logic   ovf_x, ovf_y, ovf_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      qw <= QUAT_ONE;
      qx <= '0;
      qy <= '0;
      qz <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_QUAT_W: qw <= cfg_data;
        REG_QUAT_X: qx <= cfg_data;
        REG_QUAT_Y: qy <= cfg_data;
        REG_QUAT_Z: qz <= cfg_data;
        default:    ;
      endcase
    end
  end

  assign adv      = !v5 || m_tready;
  assign s_tready = adv;
  assign m_tvalid = v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (adv) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // stage 1: capture point, pair products of the quaternion
  always_ff @(posedge clk) begin
    if (adv) begin
      px1 <= s_tdata[COORD_W-1:0];
      py1 <= s_tdata[2*COORD_W-1:COORD_W];
      pz1 <= s_tdata[3*COORD_W-1:2*COORD_W];
      xx  <= PAIR_W'(qx) * PAIR_W'(qx);
      xy  <= PAIR_W'(qx) * PAIR_W'(qy);
      xz  <= PAIR_W'(qx) * PAIR_W'(qz);
      xw  <= PAIR_W'(qx) * PAIR_W'(qw);
      yy  <= PAIR_W'(qy) * PAIR_W'(qy);
      yz  <= PAIR_W'(qy) * PAIR_W'(qz);
      yw  <= PAIR_W'(qy) * PAIR_W'(qw);
      zz  <= PAIR_W'(qz) * PAIR_W'(qz);
      zw  <= PAIR_W'(qz) * PAIR_W'(qw);
    end
  end

  // stage 2: R' = rotation matrix minus identity, halved
  always_ff @(posedge clk) begin
    if (adv) begin
      px2 <= px1;
      py2 <= py1;
      pz2 <= pz1;
      e00 <= -(ENTRY_W'(yy) + ENTRY_W'(zz));
      e01 <= ENTRY_W'(xy) - ENTRY_W'(zw);
      e02 <= ENTRY_W'(xz) + ENTRY_W'(yw);
      e10 <= ENTRY_W'(xy) + ENTRY_W'(zw);
      e11 <= -(ENTRY_W'(xx) + ENTRY_W'(zz));
      e12 <= ENTRY_W'(yz) - ENTRY_W'(xw);
      e20 <= ENTRY_W'(xz) - ENTRY_W'(yw);
      e21 <= ENTRY_W'(yz) + ENTRY_W'(xw);
      e22 <= -(ENTRY_W'(xx) + ENTRY_W'(yy));
    end
  end

  // stages 3 to 5, one per axis
  qvr_axis u_axis_x (
    .clk(clk), .adv(adv), .px(px2), .py(py2), .pz(pz2),
    .m0(e00), .m1(e01), .m2(e02), .v(px2), .rot(rot_x), .ovf(ovf_x)
  );

  qvr_axis u_axis_y (
    .clk(clk), .adv(adv), .px(px2), .py(py2), .pz(pz2),
    .m0(e10), .m1(e11), .m2(e12), .v(py2), .rot(rot_y), .ovf(ovf_y)
  );

  qvr_axis u_axis_z (
    .clk(clk), .adv(adv), .px(px2), .py(py2), .pz(pz2),
    .m0(e20), .m1(e21), .m2(e22), .v(pz2), .rot(rot_z), .ovf(ovf_z)
  );

  assign m_tdata = {rot_z, rot_y, rot_x};
  assign m_tuser = ovf_x | ovf_y | ovf_z;

endmodule

`default_nettype wire

// ===== src/qvr_axis.sv =====
// ----------------------------------------------------------------------------
// qvr_axis
// One output coordinate: row of R' times the point, rounded, added, saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module qvr_axis (
  input  wire logic            clk,
  input  wire logic            adv,   // pipeline advance
  input  wire qvr_pkg::coord_t px,
  input  wire qvr_pkg::coord_t py,
  input  wire qvr_pkg::coord_t pz,
  input  wire qvr_pkg::entry_t m0,
  input  wire qvr_pkg::entry_t m1,
  input  wire qvr_pkg::entry_t m2,
  input  wire qvr_pkg::coord_t v,     // coordinate being corrected
  output qvr_pkg::coord_t      rot,
  output logic                 ovf
);
  import qvr_pkg::*;

  localparam logic signed [DOT_W-1:0] ROUND_HALF = DOT_W'(1) << (SHIFT - 1);
  localparam logic signed [RES_W-1:0] RES_MAX =
    {{(RES_W - COORD_W + 1){1'b0}}, {(COORD_W - 1){1'b1}}};
  localparam logic signed [RES_W-1:0] RES_MIN =
    {{(RES_W - COORD_W + 1){1'b1}}, {(COORD_W - 1){1'b0}}};
  localparam coord_t COORD_MAX = {1'b0, {(COORD_W - 1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_W - 1){1'b0}}};

  logic signed [PROD_W-1:0] p0, p1, p2;
  coord_t                   v3, v4;
  logic signed [DOT_W-1:0]  dot;
  logic signed [CORR_W-1:0] corr;
  logic signed [RES_W-1:0]  res;

  // stage 3: products
  always_ff @(posedge clk) begin
    if (adv) begin
      p0 <= PROD_W'(px) * PROD_W'(m0);
      p1 <= PROD_W'(py) * PROD_W'(m1);
      p2 <= PROD_W'(pz) * PROD_W'(m2);
      v3 <= v;
    end
  end

  // stage 4: dot product plus rounding half
  always_ff @(posedge clk) begin
    if (adv) begin
      dot <= DOT_W'(p0) + DOT_W'(p1) + DOT_W'(p2) + ROUND_HALF;
      v4  <= v3;
    end
  end

  // stage 5: floor shift, add, clamp
  assign corr = dot[DOT_W-1:SHIFT];
  assign res  = RES_W'(corr) + RES_W'(v4);

  always_ff @(posedge clk) begin
    if (adv) begin
      if (res > RES_MAX) begin
        rot <= COORD_MAX;
        ovf <= 1'b1;
      end else if (res < RES_MIN) begin
        rot <= COORD_MIN;
        ovf <= 1'b1;
      end else begin
        rot <= res[COORD_W-1:0];
        ovf <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/qvr_checker.sv =====
// ----------------------------------------------------------------------------
// qvr_checker
// Port-level checks for the quaternion rotation core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module qvr_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          s_tvalid,
  input wire logic                          s_tready,
  input wire logic [3*qvr_pkg::COORD_W-1:0] s_tdata,
  input wire logic                          m_tvalid,
  input wire logic                          m_tready,
  input wire logic [3*qvr_pkg::COORD_W-1:0] m_tdata,
  input wire logic                          m_tuser,
  input wire logic                          cfg_we,
  input wire logic [qvr_pkg::CFG_IDX_W-1:0] cfg_index,
  input wire logic [qvr_pkg::QUAT_W-1:0]    cfg_data
);
  import qvr_pkg::*;

  localparam coord_t CMAX = {1'b0, {(COORD_W - 1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(COORD_W - 1){1'b0}}};

  coord_t ox, oy, oz;
  logic   unused_in;

  assign ox = m_tdata[COORD_W-1:0];
  assign oy = m_tdata[2*COORD_W-1:COORD_W];
  assign oz = m_tdata[3*COORD_W-1:2*COORD_W];
  assign unused_in = s_tvalid ^ (^s_tdata) ^ cfg_we ^ (^cfg_index) ^ (^cfg_data);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // an empty output register never blocks the input
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // overflow only comes with a clamped coordinate
  a_ovf: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (ox == CMAX || ox == CMIN || oy == CMAX ||
                             oy == CMIN || oz == CMAX || oz == CMIN))
    else $error("overflow flagged without a clamped coordinate");

endmodule

bind quaternion_vector_rotation_core qvr_checker u_qvr_checker (
  .clk(clk), .rst(rst),
  .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
  .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
);

`default_nettype wire
